// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mbup_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI to USB-MIDI packet package
// Shared types, codes and helpers for the byte stream packetizer.
// ----------------------------------------------------------------------------
package mbup_pkg;

    localparam int MSG_BYTES = 3;
    localparam int CNT_W     = $clog2(MSG_BYTES + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MSG_BYTES);

    // USB-MIDI code index numbers
    localparam logic [3:0] CIN_INVALID = 4'h0;
    localparam logic [3:0] CIN_SYSEX   = 4'h4;
    localparam logic [3:0] CIN_SINGLE  = 4'hF;

    // MIDI status bytes
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_MTC_QF    = 8'hF1;
    localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] ST_TUNE_REQ  = 8'hF6;
    localparam logic [7:0] ST_EOX       = 8'hF7;
    localparam logic [7:0] ST_REALTIME  = 8'hF8;

    typedef struct packed {
        logic [MSG_BYTES-1:0][7:0] msg;
        logic [CNT_W-1:0]          cnt;
        logic                      done;
        logic [7:0]                run_status;
        logic                      in_sysex;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] code_index;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       invalid;
    } parse_result_t;

    function automatic logic is_channel(input logic [7:0] b);
        return b[7] && (b[7:4] != 4'hF);
    endfunction

endpackage

// ===== hdl/midi_byte_to_usb_midi_packet.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream to USB-MIDI event packets
// Top level: input register, byte parser and packet output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one MIDI byte per request; m_tdata carries one USB-MIDI
//   event packet per request, m_tuser flags a rejected byte.
//   cfg_data sets the cable number; write it only while no byte is in flight.
//   cfg_ready is always high.
// Path: an accepted byte sits in the input register, then its packet loads
//   the output register, which drives m_tvalid.
// Throughput: one byte per cycle while the output is not stalled. The parser
//   state is a handful of registers updated by a single pass of logic from
//   the input register, so a byte can follow in the next cycle.
// Reset: aresetn low empties both registers, clears the partial message,
//   the running status, the SysEx flag and the cable number.
// Stall: while m_tready is low a waiting packet holds; the input register
//   still accepts one byte, then s_tready drops until the packet is taken.
// Bytes that produce no packet (partial messages, SysEx data) still advance
//   only when the output register can take a result.
// ----------------------------------------------------------------------------
module midi_byte_to_usb_midi_packet
    import mbup_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,     // [3:0] cable_number

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [3:0] code_index, [7:4] cable,
                                      // [15:8] byte0, [23:16] byte1, [31:24] byte2
    output logic        m_tuser       // [0] invalid
);

    logic [3:0]    cable_reg;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;

    parse_state_t  st_reg;
    parse_state_t  st_next;
    parse_result_t res;

    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic          out_user_reg;

    logic          advance;

    // Process the held byte when the output register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    mbup_parser u_parser (
        .data_byte (in_byte_reg),
        .st_cur    (st_reg),
        .st_next   (st_next),
        .res       (res)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cable_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            cable_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parser state: advance once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_data_reg <= {res.byte2, res.byte1, res.byte0, cable_reg, res.code_index};
            out_user_reg <= res.invalid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== hdl/mbup_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI byte parser
// Next-state and packet logic for one received MIDI byte.
// ----------------------------------------------------------------------------
module mbup_parser
    import mbup_pkg::*;
(
    input  logic [7:0]    data_byte,
    input  parse_state_t  st_cur,
    output parse_state_t  st_next,
    output parse_result_t res
);

    always_comb begin
        parse_state_t  ns;
        parse_result_t r;
        logic          data_ok;
        logic          two_byte;
        logic [CNT_W-1:0] need;

        ns       = st_cur;
        r        = '0;
        data_ok  = 1'b0;
        two_byte = 1'b0;
        need     = CNT_FULL;

        // drop a finished message before taking the new byte
        if (ns.done || ns.cnt == CNT_FULL) begin
            ns.msg  = '0;
            ns.cnt  = '0;
            ns.done = 1'b0;
        end

        if (data_byte >= ST_REALTIME) begin
            r.valid      = 1'b1;
            r.code_index = CIN_SINGLE;
            r.byte0      = data_byte;
        end else if (ns.in_sysex) begin
            if (!data_byte[7]) begin
                ns.msg[ns.cnt[1:0]] = data_byte;
                ns.cnt              = ns.cnt + 1'b1;
                if (ns.cnt == CNT_FULL) begin
                    r.valid      = 1'b1;
                    r.code_index = CIN_SYSEX;
                    r.byte0      = ns.msg[0];
                    r.byte1      = ns.msg[1];
                    r.byte2      = ns.msg[2];
                    ns.done      = 1'b1;
                end
            end else begin
                // close the SysEx with an end-of-exclusive in place of this byte
                ns.msg[ns.cnt[1:0]] = ST_EOX;
                r.valid      = 1'b1;
                r.code_index = CIN_SYSEX + 4'(ns.cnt + 1'b1);
                r.byte0      = ns.msg[0];
                r.byte1      = ns.msg[1];
                r.byte2      = ns.msg[2];
                ns.in_sysex  = 1'b0;
                ns.msg       = '0;
                ns.cnt       = '0;
                ns.done      = 1'b0;
                if (data_byte != ST_EOX) begin
                    if (is_channel(data_byte)) begin
                        ns.msg[0]     = data_byte;
                        ns.cnt        = CNT_W'(1);
                        ns.run_status = data_byte;
                    end else begin
                        ns.run_status = '0;
                        if (data_byte == ST_SYSEX) begin
                            ns.in_sysex = 1'b1;
                            ns.msg[0]   = data_byte;
                            ns.cnt      = CNT_W'(1);
                        end
                    end
                end
            end
        end else if (!data_byte[7]) begin
            data_ok = 1'b1;
            if (ns.cnt != '0 && is_channel(ns.msg[0])) begin
                ns.msg[ns.cnt[1:0]] = data_byte;
                ns.cnt              = ns.cnt + 1'b1;
            end else if (is_channel(ns.run_status)) begin
                // running status: restart the message from the held status
                ns.msg    = '0;
                ns.msg[0] = ns.run_status;
                ns.msg[1] = data_byte;
                ns.cnt    = CNT_W'(2);
                ns.done   = 1'b0;
            end else begin
                ns.msg     = '0;
                ns.cnt     = '0;
                ns.done    = 1'b0;
                data_ok    = 1'b0;
                r.valid    = 1'b1;
                r.byte0    = data_byte;
                r.invalid  = 1'b1;
                r.code_index = CIN_INVALID;
            end
            if (data_ok) begin
                // program change and channel pressure carry one data byte
                two_byte = (ns.msg[0][7:5] == 3'b110);
                need     = two_byte ? CNT_W'(2) : CNT_W'(3);
                if (ns.cnt >= need) begin
                    r.valid      = 1'b1;
                    r.code_index = ns.msg[0][7:4];
                    r.byte0      = ns.msg[0];
                    r.byte1      = ns.msg[1];
                    r.byte2      = two_byte ? 8'h00 : ns.msg[2];
                    ns.done      = 1'b1;
                end
            end
        end else begin
            ns.msg  = '0;
            ns.cnt  = '0;
            ns.done = 1'b0;
            if (is_channel(data_byte)) begin
                ns.msg[0]     = data_byte;
                ns.cnt        = CNT_W'(1);
                ns.run_status = data_byte;
            end else begin
                ns.run_status = '0;
                if (data_byte == ST_SYSEX) begin
                    ns.in_sysex = 1'b1;
                    ns.msg[0]   = data_byte;
                    ns.cnt      = CNT_W'(1);
                end else if (data_byte == ST_MTC_QF || data_byte == ST_UNDEF_F4 ||
                             data_byte == ST_TUNE_REQ) begin
                    r.valid      = 1'b1;
                    r.code_index = CIN_SINGLE;
                    r.byte0      = data_byte;
                end else begin
                    r.valid      = 1'b1;
                    r.code_index = CIN_INVALID;
                    r.byte0      = data_byte;
                    r.invalid    = 1'b1;
                end
            end
        end

        st_next = ns;
        res     = r;
    end

endmodule

// ===== hdl/mbup_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI to USB-MIDI packet checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbup_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled packet holds its contents
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "packet changed while stalled")

    // Reset leaves no packet pending
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "packet pending after reset")

    // A rejected byte carries code zero and no further bytes
    `ASSERT_CLK(a_invalid_shape, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[3:0] == 4'h0 && m_tdata[31:16] == 16'h0, "malformed invalid result")

    // A good packet never carries a reserved code index
    `ASSERT_CLK(a_code_range, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[3:2] != 2'b00, "reserved code index")

    // A single-byte packet holds a system status and nothing else
    `ASSERT_CLK(a_single_shape, aclk, aresetn, m_tvalid && !m_tuser && m_tdata[3:0] == 4'hF |-> m_tdata[15:12] == 4'hF && m_tdata[31:16] == 16'h0, "malformed single-byte packet")

endmodule

bind midi_byte_to_usb_midi_packet mbup_checker u_mbup_checker (.*);

// ===== bench/tb_midi_byte_to_usb_midi_packet.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream to USB-MIDI packet testbench
// Feeds MIDI bytes into the packetizer, predicts every USB-MIDI event packet
// with an independent parser and checks each packet in order. A short table
// of directed bytes comes first, then random message streams over several
// cable numbers, with random gaps on both sides, a long output stall and
// idle pauses between phases.
// ----------------------------------------------------------------------------
module tb_midi_byte_to_usb_midi_packet
    import mbup_pkg::*;
();

    localparam int IDLE_LIMIT    = 2000;  // cycles without any request
    localparam int HOLD_CYCLES   = 300;   // long output stall
    localparam int SETTLE_CYCLES = 8;     // covers the two-register latency
    localparam int PHASE_ITEMS   = 255;

    typedef struct packed {
        logic [3:0] cin;
        logic [3:0] cable;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       invalid;
    } usb_packet_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;   // packet below is the literal expectation
        usb_packet_t pkt;
    } midi_row_t;

    localparam usb_packet_t NO_PKT = '0;

    // Directed bytes, cable number 0. Literal packets only where obvious.
    localparam int DIR_ROWS = 33;
    localparam midi_row_t DIRECTED [DIR_ROWS] = '{
        {8'hF8, 1'b1, CIN_SINGLE,  4'h0, 8'hF8, 16'h0000, 1'b0},  // real-time
        {8'hFF, 1'b1, CIN_SINGLE,  4'h0, 8'hFF, 16'h0000, 1'b0},
        {8'h00, 1'b1, CIN_INVALID, 4'h0, 8'h00, 16'h0000, 1'b1},  // no status
        {8'h7F, 1'b1, CIN_INVALID, 4'h0, 8'h7F, 16'h0000, 1'b1},
        {8'hF7, 1'b1, CIN_INVALID, 4'h0, 8'hF7, 16'h0000, 1'b1},  // stray EOX
        {8'hF2, 1'b1, CIN_INVALID, 4'h0, 8'hF2, 16'h0000, 1'b1},
        {8'hF3, 1'b1, CIN_INVALID, 4'h0, 8'hF3, 16'h0000, 1'b1},
        {8'hF5, 1'b1, CIN_INVALID, 4'h0, 8'hF5, 16'h0000, 1'b1},
        {8'hF4, 1'b1, CIN_SINGLE,  4'h0, 8'hF4, 16'h0000, 1'b0},
        {8'hF6, 1'b1, CIN_SINGLE,  4'h0, 8'hF6, 16'h0000, 1'b0},
        {8'h90, 1'b0, NO_PKT},                                    // note on
        {8'h3C, 1'b0, NO_PKT},
        {8'hF8, 1'b1, CIN_SINGLE,  4'h0, 8'hF8, 16'h0000, 1'b0},  // mid-message
        {8'h7F, 1'b0, NO_PKT},
        {8'h00, 1'b0, NO_PKT},                                    // running status
        {8'h40, 1'b0, NO_PKT},
        {8'hC5, 1'b0, NO_PKT},                                    // program change
        {8'h7F, 1'b0, NO_PKT},
        {8'hF0, 1'b0, NO_PKT},                                    // SysEx
        {8'h01, 1'b0, NO_PKT},
        {8'h02, 1'b0, NO_PKT},
        {8'hFE, 1'b1, CIN_SINGLE,  4'h0, 8'hFE, 16'h0000, 1'b0},  // inside SysEx
        {8'h03, 1'b0, NO_PKT},
        {8'hE0, 1'b0, NO_PKT},                                    // ends SysEx
        {8'h00, 1'b0, NO_PKT},
        {8'h7F, 1'b0, NO_PKT},
        {8'hF0, 1'b0, NO_PKT},
        {8'h01, 1'b0, NO_PKT},
        {8'hF1, 1'b0, NO_PKT},                                    // ends SysEx
        {8'h55, 1'b1, CIN_INVALID, 4'h0, 8'h55, 16'h0000, 1'b1},  // status cleared
        {8'hF0, 1'b0, NO_PKT},
        {8'h01, 1'b0, NO_PKT},
        {8'h02, 1'b0, NO_PKT}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // Parser copy: partial message, running status, SysEx flag, cable.
    logic [7:0]  part_bytes [3] = '{8'h00, 8'h00, 8'h00};
    logic [1:0]  part_count     = 2'd0;
    logic        part_done      = 1'b0;
    logic [7:0]  running_status = 8'h00;
    logic        sysex_open     = 1'b0;
    logic [3:0]  cable_sel      = 4'h0;

    usb_packet_t awaited_packets [$];
    logic [7:0]  midi_burst [$];
    logic [7:0]  gen_status = 8'h00;   // last channel status the generator sent

    // Expectation carried with the byte on offer
    logic        cur_typed;
    usb_packet_t cur_pkt;

    bit quiet_src  = 1'b0;   // no gaps on the input side
    bit quiet_sink = 1'b0;   // no gaps on the output side
    bit hold_sink  = 1'b0;   // request a long output stall
    int mismatch_count = 0;
    int idle_cycles = 0;

    midi_byte_to_usb_midi_packet dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit chan_status(input logic [7:0] b);
        return (b >= 8'h80) && (b < 8'hF0);
    endfunction

    function automatic void drop_partial();
        part_bytes = '{8'h00, 8'h00, 8'h00};
        part_count = 2'd0;
        part_done  = 1'b0;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        if (part_count < 2'd3) begin
            part_bytes[part_count] = b;
            part_count = part_count + 2'd1;
        end
    endfunction

    // Advance the parser copy by one byte; return 1 when a packet results.
    function automatic bit parse_midi_byte(input logic [7:0] b, output usb_packet_t pkt);
        logic [7:0] st;
        logic [1:0] need;
        pkt = '0;
        pkt.cable = cable_sel;
        if (part_done || part_count == 2'd3) drop_partial();

        // Real-time bytes pass straight through, state untouched
        if (b >= ST_REALTIME) begin
            pkt.cin   = CIN_SINGLE;
            pkt.byte0 = b;
            return 1'b1;
        end

        if (sysex_open) begin
            if (!b[7]) begin
                add_byte(b);
                if (part_count == 2'd3) begin
                    pkt.cin   = CIN_SYSEX;
                    pkt.byte0 = part_bytes[0];
                    pkt.byte1 = part_bytes[1];
                    pkt.byte2 = part_bytes[2];
                    part_done = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            // Any status byte closes the SysEx with an end packet
            add_byte(ST_EOX);
            pkt.cin   = CIN_SYSEX + 4'(part_count);
            pkt.byte0 = part_bytes[0];
            pkt.byte1 = part_bytes[1];
            pkt.byte2 = part_bytes[2];
            sysex_open = 1'b0;
            drop_partial();
            if (b == ST_EOX) return 1'b1;
            if (chan_status(b)) begin
                part_bytes[0]  = b;
                part_count     = 2'd1;
                running_status = b;
            end else begin
                running_status = 8'h00;
                if (b == ST_SYSEX) begin
                    sysex_open    = 1'b1;
                    part_bytes[0] = b;
                    part_count    = 2'd1;
                end
            end
            return 1'b1;
        end

        if (!b[7]) begin
            if (part_count > 2'd0 && chan_status(part_bytes[0])) begin
                add_byte(b);
            end else if (chan_status(running_status)) begin
                drop_partial();
                part_bytes[0] = running_status;
                part_bytes[1] = b;
                part_count    = 2'd2;
            end else begin
                drop_partial();
                pkt.cin     = CIN_INVALID;
                pkt.byte0   = b;
                pkt.invalid = 1'b1;
                return 1'b1;
            end
            st   = part_bytes[0];
            need = (st[7:5] == 3'b110) ? 2'd2 : 2'd3;
            if (part_count >= need) begin
                pkt.cin   = st[7:4];
                pkt.byte0 = st;
                pkt.byte1 = part_bytes[1];
                pkt.byte2 = (need == 2'd3) ? part_bytes[2] : 8'h00;
                part_done = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end

        drop_partial();
        if (chan_status(b)) begin
            part_bytes[0]  = b;
            part_count     = 2'd1;
            running_status = b;
            return 1'b0;
        end
        running_status = 8'h00;
        if (b == ST_SYSEX) begin
            sysex_open    = 1'b1;
            part_bytes[0] = b;
            part_count    = 2'd1;
            return 1'b0;
        end
        pkt.byte0 = b;
        if (b == ST_MTC_QF || b == ST_UNDEF_F4 || b == ST_TUNE_REQ) begin
            pkt.cin = CIN_SINGLE;
        end else begin
            pkt.cin     = CIN_INVALID;
            pkt.invalid = 1'b1;
        end
        return 1'b1;
    endfunction

    // Append a random data byte, now and then with a real-time byte ahead of it.
    function automatic void push_data();
        if ($urandom_range(0, 11) == 0) midi_burst.push_back(8'($urandom_range(248, 255)));
        midi_burst.push_back(8'($urandom_range(0, 127)));
    endfunction

    // Queue one random message: mostly well formed, some broken, some noise.
    function automatic void build_message();
        int kind;
        int len;
        logic [7:0] st;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // Channel message; skip the status now and then to use running status
            st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            if ($urandom_range(0, 3) == 0 && gen_status != 8'h00) begin
                st = gen_status;
            end else begin
                midi_burst.push_back(st);
                gen_status = st;
            end
            len = (st[7:5] == 3'b110) ? 1 : 2;
            for (int i = 0; i < len; i++) push_data();
        end else if (kind < 65) begin
            // SysEx of random length, mostly closed by EOX
            midi_burst.push_back(ST_SYSEX);
            gen_status = 8'h00;
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++) push_data();
            if ($urandom_range(0, 3) != 0) midi_burst.push_back(ST_EOX);
            else midi_burst.push_back(8'($urandom_range(128, 255)));
        end else if (kind < 78) begin
            case ($urandom_range(0, 3))
                0: midi_burst.push_back(ST_MTC_QF);
                1: midi_burst.push_back(ST_UNDEF_F4);
                2: midi_burst.push_back(ST_TUNE_REQ);
                default: midi_burst.push_back(8'($urandom_range(248, 255)));
            endcase
            gen_status = 8'h00;
        end else if (kind < 88) begin
            // Truncated channel message
            st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            midi_burst.push_back(st);
            gen_status = st;
            if (st[7:5] != 3'b110 && $urandom_range(0, 1) == 1) push_data();
        end else begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) midi_burst.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offer one byte after a random gap and hold it until the request completes.
    task automatic send_byte(input logic [7:0] b, input logic typed, input usb_packet_t pkt);
        int gap;
        gap = quiet_src ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        cur_typed <= typed;
        cur_pkt   <= pkt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop the input request, wait for every packet, then let the pipe settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_packets.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cable(input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Predict on every accepted byte, check every accepted packet.
    always @(posedge aclk) begin
        usb_packet_t want;
        usb_packet_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) cable_sel = cfg_data;
            if (s_tvalid && s_tready) begin
                if (parse_midi_byte(s_tdata, want)) begin
                    awaited_packets.push_back(cur_typed ? cur_pkt : want);
                end else if (cur_typed) begin
                    awaited_packets.push_back(cur_pkt);
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[3:0], m_tdata[7:4], m_tdata[15:8], m_tdata[23:16],
                       m_tdata[31:24], m_tuser};
                if (awaited_packets.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected packet cin=%h cable=%h %h %h %h invalid=%b",
                             $time, got.cin, got.cable, got.byte0, got.byte1,
                             got.byte2, got.invalid);
                end else begin
                    want = awaited_packets.pop_front();
                    if (got.cin !== want.cin || got.cable !== want.cable ||
                        got.byte0 !== want.byte0 || got.byte1 !== want.byte1 ||
                        got.byte2 !== want.byte2 || got.invalid !== want.invalid) begin
                        mismatch_count++;
                        $display("%0t: packet mismatch: expected cin=%h cable=%h %h %h %h",
                                 $time, want.cin, want.cable, want.byte0, want.byte1,
                                 want.byte2, " invalid=%b, got cin=%h cable=%h %h %h %h",
                                 want.invalid, got.cin, got.cable, got.byte0,
                                 got.byte1, got.byte2, " invalid=%b", got.invalid);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no request moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no request for %0d cycles", $time, IDLE_LIMIT);
                $display("midi_byte_to_usb_midi_packet regression: fail");
                $finish;
            end
        end
    end

    // Output side: random back-pressure per packet, one long stall on request.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_sink = 1'b0;
            end else begin
                gap = quiet_sink ? 0 : $urandom_range(0, 13);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        int sent;
        logic [3:0] cable;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 4'h0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cur_typed = 1'b0;
        cur_pkt   = NO_PKT;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at cable 0
        write_cable(4'h0);
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].pkt);
        wait_drained();

        // Random phases: change the cable only while the block is idle
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: cable = 4'hF;
                2: cable = 4'h0;
                4: cable = 4'h5;
                default: cable = 4'($urandom_range(0, 15));
            endcase
            write_cable(cable);
            quiet_src  = (phase == 1);
            quiet_sink = (phase == 1) || (phase == 2);
            hold_sink  = (phase == 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_message();
                while (midi_burst.size() > 0) begin
                    send_byte(midi_burst.pop_front(), 1'b0, NO_PKT);
                    sent++;
                end
            end
            wait_drained();
        end

        // Give any stray packet time to show up
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("midi_byte_to_usb_midi_packet regression: pass");
        end else begin
            $display("midi_byte_to_usb_midi_packet regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mbup_pkg.sv
hdl/mbup_parser.sv
hdl/midi_byte_to_usb_midi_packet.sv
hdl/mbup_checker.sv
bench/tb_midi_byte_to_usb_midi_packet.sv
